[hdl/bca_pkg.sv]
// ----------------------------------------------------------------------------
// bca_pkg
// Shared constants, codes and control types of the block chain allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int LINK_W     = IDX_W + 1;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int NUM_WORDS  = NUM_BLOCKS / WORD_BITS;
   localparam int WORD_W     = ADDR_W - BIT_W;

   localparam logic [CNT_W-1:0] POOL_LIMIT =
      CNT_W'((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024);
   localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(1024);
   localparam logic [LINK_W-1:0] LINK_END = {1'b1, {IDX_W{1'b0}}};

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_LINK,
      CMD_FREE_CHAIN,
      CMD_FIND_TAIL
   } bca_cmd_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_RANGE,
      STAT_LOOP
   } bca_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_DONE
   } bca_state_type;

   typedef struct packed {
      logic ready;
      logic init_wr;
      logic decode;
      logic scan_rd;
      logic scan_ev;
      logic walk_rd;
      logic walk_ev;
      logic publish;
   } bca_ctl_type;

   typedef struct packed {
      logic        init_last;
      bca_cmd_type cmd;
      logic        start_bad;
      logic        scan_done;
      logic        walk_done;
      logic        out_free;
   } bca_sts_type;

endpackage

[hdl/bca_req_if.sv]
// ----------------------------------------------------------------------------
// bca_req_if
// Command channel: valid/ready handshake with one command per transfer.
// ----------------------------------------------------------------------------
interface bca_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [bca_pkg::IDX_W-1:0] block;
   logic [bca_pkg::IDX_W-1:0] next_block;
   logic                      next_is_end;

   modport source (output valid, cmd, block, next_block, next_is_end, input ready);
   modport sink   (input valid, cmd, block, next_block, next_is_end, output ready);
endinterface

[hdl/bca_rsp_if.sv]
// ----------------------------------------------------------------------------
// bca_rsp_if
// Response channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface bca_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bca_pkg::IDX_W-1:0] result_block;
   logic [bca_pkg::CNT_W-1:0] freed_count;
   logic [1:0]                status;

   modport source (output valid, result_block, freed_count, status, input ready);
   modport sink   (input valid, result_block, freed_count, status, output ready);
endinterface

[hdl/block_chain_allocator_top.sv]
// ----------------------------------------------------------------------------
// block_chain_allocator_top
// Block pool with used bitmap and next-block link table: alloc, link,
// free_chain and find_tail commands, one response per command.
// ----------------------------------------------------------------------------
//   channel   dir   handshake     payload
//   req_if    in    valid/ready   cmd, block, next_block, next_is_end
//   rsp_if    out   valid/ready   result_block, freed_count, status
//   csr       in    csr_we        csr_wdata = block_count
//
// link is written at decode; alloc scans the bitmap one 32-block word at a time;
// free_chain and find_tail do one link table read per chain visit
// reset starts a clearing pass over the link table and bitmap, no
// command is taken during it (csr writes are)
// one command is in flight at a time; the next is taken while the last
// response still waits in its output register
// ----------------------------------------------------------------------------
module block_chain_allocator_top (
   input  logic                      clock,
   input  logic                      reset,
   bca_req_if.sink                   req_if,
   bca_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [bca_pkg::CNT_W-1:0] csr_wdata
);
   import bca_pkg::*;

   bca_ctl_type ctl;
   bca_sts_type sts;

   bca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   bca_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule

[hdl/bca_ctrl.sv]
// ----------------------------------------------------------------------------
// bca_ctrl
// Sequencer: clearing pass after reset, then command decode, bitmap scan,
// chain walk and response hand-off.
// ----------------------------------------------------------------------------
module bca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  bca_pkg::bca_sts_type sts,
   output bca_pkg::bca_ctl_type ctl
);
   import bca_pkg::*;

   bca_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (sts.cmd)
               CMD_ALLOC:      state_in = ST_SCAN_RD;
               CMD_LINK:       state_in = ST_DONE;
               CMD_FREE_CHAIN,
               CMD_FIND_TAIL:  state_in = sts.start_bad ? ST_DONE : ST_WALK_RD;
               default:        state_in = ST_DONE;
            endcase
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            state_in = sts.scan_done ? ST_DONE : ST_SCAN_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_EV;
         ST_WALK_EV: begin
            state_in = sts.walk_done ? ST_DONE : ST_WALK_RD;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_INIT:    ctl.init_wr = 1'b1;
         ST_IDLE:    ctl.ready   = 1'b1;
         ST_DECODE:  ctl.decode  = 1'b1;
         ST_SCAN_RD: ctl.scan_rd = 1'b1;
         ST_SCAN_EV: ctl.scan_ev = 1'b1;
         ST_WALK_RD: ctl.walk_rd = 1'b1;
         ST_WALK_EV: ctl.walk_ev = 1'b1;
         ST_DONE:    ctl.publish = sts.out_free;
         default:    ctl = '0;
      endcase
   end

   // a walk that ends must hand over its result next
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_EV && sts.walk_done) |=> (state_ff == ST_DONE))
      else $error("walk end did not reach response state");

   // no command is taken before the clearing pass is over
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !ctl.ready)
      else $error("command accepted during clearing pass");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.init_wr, ctl.decode, ctl.scan_rd, ctl.scan_ev,
                ctl.walk_rd, ctl.walk_ev, ctl.publish}))
      else $error("more than one datapath action at once");

endmodule

[hdl/bca_datapath.sv]
// ----------------------------------------------------------------------------
// bca_datapath
// Used bitmap (32-bit words) and link table memories, walk and scan
// registers, pool size register and the response register.
// ----------------------------------------------------------------------------
module bca_datapath (
   input  logic                        clock,
   input  logic                        reset,
   bca_req_if.sink                     req_if,
   bca_rsp_if.source                   rsp_if,
   input  logic                        csr_we,
   input  logic [bca_pkg::CNT_W-1:0]   csr_wdata,
   input  bca_pkg::bca_ctl_type        ctl,
   output bca_pkg::bca_sts_type        sts
);
   import bca_pkg::*;

   logic [LINK_W-1:0]    link_mem [NUM_BLOCKS];
   logic [WORD_BITS-1:0] used_mem [NUM_WORDS];

   logic [CNT_W-1:0]     block_count_ff;
   logic [ADDR_W-1:0]    init_addr_ff;
   logic                 rsp_valid_ff;

   bca_cmd_type          cmd_ff,   cmd_in;
   logic [IDX_W-1:0]     blk_ff,   blk_in;
   logic [IDX_W-1:0]     nxt_ff,   nxt_in;
   logic                 end_ff,   end_in;
   logic [ADDR_W-1:0]    cur_ff,   cur_in;
   logic [CNT_W-1:0]     visits_ff, visits_in;
   logic [WORD_W-1:0]    word_ff,  word_in;
   logic [IDX_W-1:0]     res_ff,   res_in;
   logic [CNT_W-1:0]     freed_ff, freed_in;
   bca_status_type       stat_ff,  stat_in;

   logic [IDX_W-1:0]     rsp_res_ff;
   logic [CNT_W-1:0]     rsp_freed_ff;
   bca_status_type       rsp_stat_ff;

   logic [LINK_W-1:0]    link_rd_ff;
   logic [WORD_BITS-1:0] used_rd_ff;

   logic [CNT_W-1:0]     lim;
   logic                 capture;
   logic                 out_free;
   logic                 start_bad;
   logic                 link_bad;
   logic [WORD_BITS-1:0] avail;
   logic                 scan_any;
   logic                 scan_last;
   logic [CNT_W:0]       next_base;
   logic [BIT_W-1:0]     low_bit;
   logic [ADDR_W-1:0]    alloc_idx;
   logic                 lk_end;
   logic                 lk_range;
   logic                 walk_loop;

   logic                 link_we;
   logic [ADDR_W-1:0]    link_waddr;
   logic [LINK_W-1:0]    link_wdata;
   logic                 used_we;
   logic [WORD_W-1:0]    used_waddr;
   logic [WORD_BITS-1:0] used_wdata;
   logic [WORD_W-1:0]    used_raddr;

   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   assign lim       = (block_count_ff > POOL_LIMIT) ? POOL_LIMIT : block_count_ff;
   assign capture   = req_if.valid && ctl.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign start_bad = {1'b0, blk_ff} >= lim;
   assign link_bad  = start_bad || (!end_ff && ({1'b0, nxt_ff} >= lim));

   // bits beyond the pool count as taken
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         avail[b] = !used_rd_ff[b] && (CNT_W'({word_ff, BIT_W'(b)}) < lim);
      end
   end

   assign scan_any  = |avail;
   assign low_bit   = lowest_set(avail);
   assign alloc_idx = {word_ff, low_bit};
   assign next_base = (CNT_W+1)'({word_ff, BIT_W'(0)}) + (CNT_W+1)'(WORD_BITS);
   assign scan_last = next_base >= {1'b0, lim};

   assign lk_end    = link_rd_ff[LINK_W-1];
   assign lk_range  = {1'b0, link_rd_ff[IDX_W-1:0]} >= lim;
   assign walk_loop = (visits_ff + CNT_W'(1)) == CNT_W'(NUM_BLOCKS);

   assign sts.init_last = init_addr_ff == ADDR_W'(NUM_BLOCKS - 1);
   assign sts.cmd       = cmd_ff;
   assign sts.start_bad = start_bad;
   assign sts.scan_done = scan_any || scan_last;
   assign sts.walk_done = lk_end || lk_range || walk_loop;
   assign sts.out_free  = out_free;

   assign req_if.ready        = ctl.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_block = rsp_res_ff;
   assign rsp_if.freed_count  = rsp_freed_ff;
   assign rsp_if.status       = rsp_stat_ff;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
         init_addr_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) block_count_ff <= csr_wdata;
         if (ctl.init_wr) init_addr_ff <= init_addr_ff + ADDR_W'(1);
         if (ctl.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- working registers ----------------
   always_comb begin
      cmd_in    = cmd_ff;
      blk_in    = blk_ff;
      nxt_in    = nxt_ff;
      end_in    = end_ff;
      cur_in    = cur_ff;
      visits_in = visits_ff;
      word_in   = word_ff;
      res_in    = res_ff;
      freed_in  = freed_ff;
      stat_in   = stat_ff;

      if (capture) begin
         cmd_in = bca_cmd_type'(req_if.cmd);
         blk_in = req_if.block;
         nxt_in = req_if.next_block;
         end_in = req_if.next_is_end;
      end

      if (ctl.decode) begin
         res_in    = '0;
         freed_in  = '0;
         stat_in   = STAT_OK;
         cur_in    = ADDR_W'(blk_ff);
         visits_in = '0;
         word_in   = '0;
         case (cmd_ff)
            CMD_LINK: begin
               if (link_bad) stat_in = STAT_RANGE;
            end
            CMD_FREE_CHAIN,
            CMD_FIND_TAIL: begin
               if (start_bad) stat_in = STAT_RANGE;
            end
            default: stat_in = STAT_OK;
         endcase
      end

      if (ctl.scan_ev) begin
         if (scan_any) begin
            res_in  = IDX_W'(alloc_idx);
            stat_in = STAT_OK;
         end else if (scan_last) begin
            stat_in = STAT_FULL;
         end else begin
            word_in = word_ff + WORD_W'(1);
         end
      end

      if (ctl.walk_ev) begin
         visits_in = visits_ff + CNT_W'(1);
         if (cmd_ff == CMD_FIND_TAIL) begin
            res_in = IDX_W'(cur_ff);
         end else begin
            freed_in = visits_ff + CNT_W'(1);
         end
         cur_in = ADDR_W'(link_rd_ff[IDX_W-1:0]);
         if (lk_end) begin
            stat_in = STAT_OK;
         end else if (lk_range) begin
            stat_in = STAT_RANGE;
         end else if (walk_loop) begin
            stat_in = STAT_LOOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      blk_ff    <= blk_in;
      nxt_ff    <= nxt_in;
      end_ff    <= end_in;
      cur_ff    <= cur_in;
      visits_ff <= visits_in;
      word_ff   <= word_in;
      res_ff    <= res_in;
      freed_ff  <= freed_in;
      stat_ff   <= stat_in;
      if (ctl.publish) begin
         rsp_res_ff   <= res_ff;
         rsp_freed_ff <= freed_ff;
         rsp_stat_ff  <= stat_ff;
      end
   end

   // ---------------- memory ports ----------------
   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = LINK_END;
      if (ctl.init_wr) begin
         link_we    = 1'b1;
         link_waddr = init_addr_ff;
      end else if (ctl.decode && cmd_ff == CMD_LINK && !link_bad) begin
         link_we    = 1'b1;
         link_waddr = ADDR_W'(blk_ff);
         link_wdata = end_ff ? LINK_END : {1'b0, nxt_ff};
      end else if (ctl.scan_ev && scan_any) begin
         link_we    = 1'b1;
         link_waddr = alloc_idx;
      end
   end

   always_comb begin
      used_we    = 1'b0;
      used_waddr = word_ff;
      used_wdata = '0;
      if (ctl.init_wr) begin
         used_we    = (init_addr_ff >> WORD_W) == '0;
         used_waddr = init_addr_ff[WORD_W-1:0];
      end else if (ctl.scan_ev && scan_any) begin
         used_we    = 1'b1;
         used_wdata = used_rd_ff | (WORD_BITS'(1) << low_bit);
      end else if (ctl.walk_ev && cmd_ff == CMD_FREE_CHAIN) begin
         used_we    = 1'b1;
         used_waddr = cur_ff[ADDR_W-1:BIT_W];
         used_wdata = used_rd_ff & ~(WORD_BITS'(1) << cur_ff[BIT_W-1:0]);
      end
   end

   assign used_raddr = ctl.scan_rd ? word_ff : cur_ff[ADDR_W-1:BIT_W];

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (ctl.walk_rd) link_rd_ff <= link_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_waddr] <= used_wdata;
      if (ctl.scan_rd || ctl.walk_rd) used_rd_ff <= used_mem[used_raddr];
   end

   // ---------------- checks ----------------
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.publish |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response overwritten before transfer");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.walk_ev |-> (visits_ff < CNT_W'(NUM_BLOCKS)))
      else $error("walk ran past the block count");

   a_alloc_in_pool: assert property (@(posedge clock) disable iff (reset)
      (ctl.publish && cmd_ff == CMD_ALLOC && stat_ff == STAT_OK)
         |-> ({1'b0, res_ff} < lim))
      else $error("allocated block outside the pool");

endmodule

[tb/block_chain_allocator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_chain_allocator_top_tb
// Drives alloc, link, free_chain and find_tail commands into the allocator
// and checks every response against a local model of the used bitmap and
// link table. Directed cases cover the pool limits, stale successors, loops
// and an empty pool. Random phases then build, walk and release chains
// under several pool sizes and idle patterns.
// ----------------------------------------------------------------------------
module block_chain_allocator_top_tb;
   import bca_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] result_block;
      logic [CNT_W-1:0] freed_count;
      bca_status_type   status;
   } alloc_outcome_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   bca_req_if req_ch ();
   bca_rsp_if rsp_ch ();

   block_chain_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // local copy of the allocator state
   logic              used_bits [NUM_BLOCKS];
   logic [LINK_W-1:0] next_link [NUM_BLOCKS];
   logic [CNT_W-1:0]  pool_reg;

   alloc_outcome_type outcomes_due [$];
   int                live_heads [$];
   int                sent_count;
   int                mismatch_count;
   int                loops_made;
   int                send_idle_pct;
   int                rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pool_size();
      int p;
      p = pool_reg;
      if (p > POOL_LIMIT) p = POOL_LIMIT;
      return p;
   endfunction

   // works out the response of one command and updates the local state
   task automatic apply_command(input bca_cmd_type c, input logic [IDX_W-1:0] blk,
                                input logic [IDX_W-1:0] nxt, input logic is_end,
                                output alloc_outcome_type o);
      int                lim;
      int                cur;
      int                visits;
      int                tail;
      bit                stop;
      logic [LINK_W-1:0] lk;
      lim = pool_size();
      o = '0;
      o.status = STAT_OK;
      case (c)
         CMD_ALLOC: begin
            o.status = STAT_FULL;
            for (int i = 0; i < lim; i++) begin
               if (!used_bits[i]) begin
                  used_bits[i] = 1'b1;
                  next_link[i] = LINK_END;
                  o.result_block = IDX_W'(i);
                  o.status = STAT_OK;
                  break;
               end
            end
         end
         CMD_LINK: begin
            if (int'(blk) >= lim || (!is_end && int'(nxt) >= lim))
               o.status = STAT_RANGE;
            else
               next_link[blk] = is_end ? LINK_END : {1'b0, nxt};
         end
         default: begin
            if (int'(blk) >= lim) begin
               o.status = STAT_RANGE;
            end else begin
               cur = blk;
               tail = blk;
               visits = 0;
               stop = 1'b0;
               o.status = STAT_LOOP;
               while (!stop && visits < NUM_BLOCKS) begin
                  if (c == CMD_FREE_CHAIN) used_bits[cur] = 1'b0;
                  visits++;
                  tail = cur;
                  lk = next_link[cur];
                  if (lk[IDX_W]) begin
                     o.status = STAT_OK;
                     stop = 1'b1;
                  end else if (int'(lk[IDX_W-1:0]) >= lim) begin
                     // successor beyond the current pool
                     o.status = STAT_RANGE;
                     stop = 1'b1;
                  end else begin
                     cur = lk[IDX_W-1:0];
                  end
               end
               if (c == CMD_FREE_CHAIN) o.freed_count = CNT_W'(visits);
               else o.result_block = IDX_W'(tail);
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // one command transfer, with random idle cycles ahead of it
   task automatic send_cmd(input bca_cmd_type c, input logic [IDX_W-1:0] blk,
                           input logic [IDX_W-1:0] nxt, input logic is_end,
                           output alloc_outcome_type o);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.block       <= blk;
      req_ch.next_block  <= nxt;
      req_ch.next_is_end <= is_end;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      apply_command(c, blk, nxt, is_end, o);
      outcomes_due.push_back(o);
      sent_count++;
   endtask

   task automatic wait_idle;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_count(input logic [CNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      pool_reg = value;
      csr_we <= 1'b0;
   endtask

   // response checker and receiver stalls
   initial begin : rsp_monitor
      alloc_outcome_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("response transfer with no command outstanding");
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_ch.result_block !== want.result_block)
                  report_mismatch($sformatf("result_block got %0d want %0d",
                                            rsp_ch.result_block, want.result_block));
               if (rsp_ch.freed_count !== want.freed_count)
                  report_mismatch($sformatf("freed_count got %0d want %0d",
                                            rsp_ch.freed_count, want.freed_count));
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_ch.status, want.status));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic test_alloc_link_walk;
      alloc_outcome_type o;
      send_cmd(CMD_ALLOC, 10'h3ff, 10'h3ff, 1'b1, o);
      send_cmd(CMD_ALLOC, 10'h000, 10'h000, 1'b0, o);
      send_cmd(CMD_LINK, 10'd0, 10'd1, 1'b0, o);
      send_cmd(CMD_LINK, 10'd1, 10'd1023, 1'b1, o);
      send_cmd(CMD_FIND_TAIL, 10'd0, 10'h3ff, 1'b1, o);
      send_cmd(CMD_FREE_CHAIN, 10'd0, 10'd0, 1'b0, o);
      // chain already released, still walked and counted
      send_cmd(CMD_FREE_CHAIN, 10'd0, 10'd0, 1'b0, o);
      // linking a free block
      send_cmd(CMD_LINK, 10'd5, 10'd0, 1'b0, o);
      send_cmd(CMD_FIND_TAIL, 10'd5, 10'd0, 1'b0, o);
      send_cmd(CMD_LINK, 10'd1, 10'd900, 1'b0, o);
   endtask

   task automatic test_pool_bounds;
      alloc_outcome_type o;
      wait_idle();
      write_block_count(CNT_W'(3));
      // 0 -> 1 -> 900 now points past the pool
      send_cmd(CMD_FIND_TAIL, 10'd0, 10'd0, 1'b0, o);
      send_cmd(CMD_FREE_CHAIN, 10'd0, 10'd0, 1'b0, o);
      send_cmd(CMD_LINK, 10'd0, 10'd3, 1'b0, o);
      send_cmd(CMD_LINK, 10'd3, 10'd0, 1'b0, o);
      send_cmd(CMD_LINK, 10'd0, 10'd1023, 1'b1, o);
      send_cmd(CMD_FIND_TAIL, 10'd1023, 10'd0, 1'b0, o);
      repeat (4) send_cmd(CMD_ALLOC, 10'd0, 10'd0, 1'b0, o);
   endtask

   task automatic test_loop_and_empty_pool;
      alloc_outcome_type o;
      wait_idle();
      write_block_count(CNT_W'(1024));
      send_cmd(CMD_LINK, 10'd5, 10'd6, 1'b0, o);
      send_cmd(CMD_LINK, 10'd6, 10'd5, 1'b0, o);
      send_cmd(CMD_FIND_TAIL, 10'd5, 10'd0, 1'b0, o);
      send_cmd(CMD_FREE_CHAIN, 10'd5, 10'd0, 1'b0, o);
      wait_idle();
      write_block_count(CNT_W'(0));
      send_cmd(CMD_ALLOC, 10'd0, 10'd0, 1'b0, o);
      send_cmd(CMD_LINK, 10'd0, 10'd0, 1'b1, o);
      send_cmd(CMD_FREE_CHAIN, 10'd0, 10'd0, 1'b0, o);
   endtask

   // mostly chains built, walked and released, with rings and noise mixed in
   task automatic run_traffic(input int n_items);
      int                stop_at;
      int                k;
      int                r;
      int                lim;
      int                blocks [$];
      alloc_outcome_type o;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         lim = pool_size();
         r = $urandom_range(99);
         if (r < 58 || (r < 73 && loops_made >= 10)) begin
            blocks.delete();
            k = (r < 58) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            repeat (k) begin
               send_cmd(CMD_ALLOC, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom), o);
               if (o.status == STAT_OK) blocks.push_back(o.result_block);
            end
            for (int i = 0; i + 1 < blocks.size(); i++)
               send_cmd(CMD_LINK, IDX_W'(blocks[i]), IDX_W'(blocks[i+1]), 1'b0, o);
            if (blocks.size() != 0) begin
               if ($urandom_range(1))
                  send_cmd(CMD_LINK, IDX_W'(blocks[$]), IDX_W'($urandom), 1'b1, o);
               send_cmd(CMD_FIND_TAIL, IDX_W'(blocks[0]), IDX_W'($urandom),
                        1'($urandom), o);
               if ($urandom_range(9) < 6 || live_heads.size() > 24)
                  send_cmd(CMD_FREE_CHAIN, IDX_W'(blocks[0]), IDX_W'($urandom),
                           1'($urandom), o);
               else
                  live_heads.push_back(blocks[0]);
            end
         end else if (r < 70) begin
            if (live_heads.size() != 0) begin
               k = $urandom_range(live_heads.size() - 1);
               if ($urandom_range(1)) begin
                  send_cmd(CMD_FREE_CHAIN, IDX_W'(live_heads[k]), IDX_W'($urandom),
                           1'($urandom), o);
                  live_heads.delete(k);
               end else begin
                  send_cmd(CMD_FIND_TAIL, IDX_W'(live_heads[k]), IDX_W'($urandom),
                           1'($urandom), o);
               end
            end
         end else if (r < 73) begin
            // ring of fresh blocks, walked to the visit bound
            blocks.delete();
            repeat ($urandom_range(1, 4)) begin
               send_cmd(CMD_ALLOC, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom), o);
               if (o.status == STAT_OK) blocks.push_back(o.result_block);
            end
            if (blocks.size() != 0) begin
               for (int i = 0; i < blocks.size(); i++)
                  send_cmd(CMD_LINK, IDX_W'(blocks[i]),
                           IDX_W'(blocks[(i + 1) % blocks.size()]), 1'b0, o);
               send_cmd(CMD_FIND_TAIL, IDX_W'(blocks[0]), IDX_W'($urandom),
                        1'($urandom), o);
               send_cmd(CMD_FREE_CHAIN, IDX_W'(blocks[0]), IDX_W'($urandom),
                        1'($urandom), o);
               loops_made++;
            end
         end else begin
            repeat ($urandom_range(1, 4))
               send_cmd(bca_cmd_type'($urandom_range(3)),
                        IDX_W'((lim > 0 && $urandom_range(1)) ?
                               $urandom_range(lim - 1) : $urandom),
                        IDX_W'((lim > 0 && $urandom_range(1)) ?
                               $urandom_range(lim - 1) : $urandom),
                        1'($urandom), o);
         end
      end
   endtask

   task automatic test_random_phases;
      wait_idle();
      write_block_count(CNT_W'(1024));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(350);

      wait_idle();
      write_block_count(CNT_W'(40));
      send_idle_pct = 83;
      rsp_stall_pct = 0;
      run_traffic(350);

      // largest register value, saturates to the pool limit
      wait_idle();
      write_block_count(CNT_W'(2047));
      send_idle_pct = 0;
      rsp_stall_pct = 83;
      run_traffic(350);

      wait_idle();
      write_block_count(CNT_W'(7));
      send_idle_pct = 29;
      rsp_stall_pct = 29;
      run_traffic(300);

      wait_idle();
      write_block_count(CNT_W'(1));
      run_traffic(100);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= BLOCK_COUNT_RESET;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_ALLOC;
      req_ch.block       <= '0;
      req_ch.next_block  <= '0;
      req_ch.next_is_end <= 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         used_bits[i] = 1'b0;
         next_link[i] = LINK_END;
      end
      pool_reg       = BLOCK_COUNT_RESET;
      sent_count     = 0;
      mismatch_count = 0;
      loops_made     = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_alloc_link_walk();
      test_pool_bounds();
      test_loop_and_empty_pool();
      test_random_phases();

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outcomes_due.size() == 0) begin
         $display("block_chain_allocator_top_tb passed");
      end else begin
         $display("block_chain_allocator_top_tb failed");
      end
      $finish;
   end

   initial begin
      #250_000_000;
      $display("block_chain_allocator_top_tb failed");
      $finish;
   end

endmodule

[block_chain_allocator_top.f]
hdl/bca_pkg.sv
hdl/bca_req_if.sv
hdl/bca_rsp_if.sv
hdl/bca_ctrl.sv
hdl/bca_datapath.sv
hdl/block_chain_allocator_top.sv
tb/block_chain_allocator_top_tb.sv
